>>> rtl/core/lpl_pkg.sv
// Shared types and constants for the look-ahead peak limiter.
// Used by the core, the checker and the bench; no dependencies.
`default_nettype none
package lpl_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int MAX_CHANNELS = 2;
  localparam int LINE_LEN_DEF = 512;
  localparam int GAIN_W       = 24;
  localparam int AGE_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [GAIN_W-1:0] UNITY = 24'd8388608;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRE_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd4;

endpackage
`default_nettype wire

>>> rtl/core/lookahead_peak_limiter_core.sv
// Look-ahead peak limiter core: sequencer, shared multiplier, bit-serial divider.
// Depends on lpl_pkg and lpl_ram (delay line, peak line, min deque).
//
// channel | signals                                   | dir
// in      | in_valid_i/in_ready_o, ch0/ch1_sample_i   | in
// out     | out_valid_o/out_ready_i, ch*_out_o, gain  | out
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
// A frame runs through the sequencer states between transactions, with a deque pass for
// each tail pop and each expired head entry, a target-gain division when the peak exceeds
// threshold and a clamp division when the clamped peak would; both use the 47 step divider.
// No clearing pass: a fill count makes unwritten delay entries read as zero.
// in_ready_o is high only between frames; a result waits in the output register,
// and a finished frame holds in its last state until that register is free.
`default_nettype none
module lookahead_peak_limiter_core #(
  parameter int LINE_LEN = lpl_pkg::LINE_LEN_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [lpl_pkg::SAMPLE_BITS-1:0] ch0_sample_i,
  input  wire logic signed [lpl_pkg::SAMPLE_BITS-1:0] ch1_sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [lpl_pkg::SAMPLE_BITS-1:0]    ch0_out_o,
  output logic signed [lpl_pkg::SAMPLE_BITS-1:0]    ch1_out_o,
  output logic [lpl_pkg::GAIN_W-1:0]                gain_now_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lpl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [lpl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int AW     = $clog2(LINE_LEN);
  localparam int FW     = $clog2(LINE_LEN + 1);
  localparam int DQ_CAP = LINE_LEN + 2;
  localparam int DQW    = $clog2(DQ_CAP);
  localparam int SB     = lpl_pkg::SAMPLE_BITS;
  localparam int AGW    = lpl_pkg::AGE_W;
  localparam int DIV_N  = 47;

  typedef enum logic [4:0] {
    S_IDLE, S_PG0, S_PG1, S_PG2, S_DIV_T, S_DQT_RD, S_DQT_CHK, S_DQ_WR,
    S_DQH_RD, S_DQH_CHK, S_REL, S_REL2, S_RD, S_CLMP0, S_CLMP1, S_DIV_C,
    S_OUT0, S_OUT1, S_OUT2, S_DONE
  } state_e;

  state_e state_q;

  logic [23:0] pg_q, thr_q, rc_q;
  logic [8:0]  la_q;
  logic [1:0]  cic_q;

  logic [SB-1:0] s0_q, s1_q, v0_q, a0_q, d0_q, d1_q, o0_q, o1_q;
  logic [23:0]   tgt_q, want_q, gain_q, ap_q, g_q;
  logic [AW-1:0] wp_q;
  logic [FW-1:0] fill_q;
  logic [DQW-1:0] head_q, tail_q;
  logic [AGW-1:0] sc_q;
  logic [47:0]   prod_q;
  logic [23:0]   div_rem_q, div_den_q;
  logic [DIV_N-1:0] div_num_q;
  logic [5:0]    div_cnt_q;
  logic          out_valid_q;
  logic [SB-1:0] out0_q, out1_q;
  logic [23:0]   outg_q;

  function automatic logic [SB-1:0] mag(input logic [SB-1:0] s);
    mag = s[SB-1] ? (~s + 1'b1) : s;
  endfunction

  // saturated signed value from a rounded magnitude
  function automatic logic [SB-1:0] sat_val(input logic [47:0] r, input logic neg);
    if (neg) begin
      sat_val = (r > 48'd8388608) ? 24'h800000 : (~r[SB-1:0] + 1'b1);
    end else begin
      sat_val = (r > 48'd8388607) ? 24'h7FFFFF : r[SB-1:0];
    end
  endfunction

  function automatic logic [SB-1:0] sat_abs(input logic [47:0] r, input logic neg);
    if (neg) begin
      sat_abs = (r > 48'd8388608) ? 24'h800000 : r[SB-1:0];
    end else begin
      sat_abs = (r > 48'd8388607) ? 24'h7FFFFF : r[SB-1:0];
    end
  endfunction

  function automatic logic [DQW-1:0] dq_inc(input logic [DQW-1:0] x);
    dq_inc = (x == DQW'(DQ_CAP - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [DQW-1:0] dq_dec(input logic [DQW-1:0] x);
    dq_dec = (x == '0) ? DQW'(DQ_CAP - 1) : x - 1'b1;
  endfunction

  // derived config
  logic          ch1_act;
  logic [AW-1:0] look;
  logic [AW-1:0] rd_addr;
  logic [AGW-1:0] window;
  assign ch1_act = (cic_q >= 2'd2);
  assign look    = (32'(la_q) > 32'(LINE_LEN - 2)) ? AW'(LINE_LEN - 2) : AW'(la_q);
  assign rd_addr = (wp_q >= look) ? (wp_q - look) : AW'(32'(wp_q) + LINE_LEN - 32'(look));
  assign window  = AGW'(look) + 1'b1;

  // rounding of the product register
  logic [47:0] r20, r23, r24;
  assign r20 = (prod_q + 48'd524288)  >> 20;
  assign r23 = (prod_q + 48'd4194304) >> 23;
  assign r24 = (prod_q + 48'd8388608) >> 24;

  // memories
  logic          ln_we;
  logic [AW-1:0] ln_addr;
  logic [2*SB-1:0] dl_rdata;
  logic [23:0]   pk_rdata;
  logic [SB-1:0] v1_c, a1_c, peak_c;
  logic          dq_we;
  logic [DQW-1:0] dq_addr;
  logic [AGW+23:0] dq_rdata;

  assign v1_c   = ch1_act ? sat_val(r20, s1_q[SB-1]) : '0;
  assign a1_c   = ch1_act ? sat_abs(r20, s1_q[SB-1]) : '0;
  assign peak_c = (a1_c > a0_q) ? a1_c : a0_q;

  assign ln_we   = (state_q == S_PG2);
  assign ln_addr = (state_q == S_PG2) ? wp_q : rd_addr;

  lpl_ram #(.WIDTH(2*SB), .DEPTH(LINE_LEN)) u_delay (
    .clk_i, .we_i(ln_we), .addr_i(ln_addr), .wdata_i({v1_c, v0_q}), .rdata_o(dl_rdata)
  );
  lpl_ram #(.WIDTH(24), .DEPTH(LINE_LEN)) u_peak (
    .clk_i, .we_i(ln_we), .addr_i(ln_addr), .wdata_i(peak_c), .rdata_o(pk_rdata)
  );

  always_comb begin
    case (state_q)
      S_DQT_RD: dq_addr = dq_dec(tail_q);
      S_DQ_WR:  dq_addr = tail_q;
      default:  dq_addr = head_q;
    endcase
  end
  assign dq_we = (state_q == S_DQ_WR);

  lpl_ram #(.WIDTH(AGW + 24), .DEPTH(DQ_CAP)) u_deque (
    .clk_i, .we_i(dq_we), .addr_i(dq_addr), .wdata_i({sc_q, tgt_q}), .rdata_o(dq_rdata)
  );

  // entries at or beyond the fill count were never written: read as zero
  logic          ln_valid;
  logic [23:0]   ap_c;
  assign ln_valid = (FW'(rd_addr) < fill_q);
  assign ap_c     = ln_valid ? pk_rdata : '0;

  // shared multiplier operands
  logic [23:0] mul_a, mul_b;
  always_comb begin
    case (state_q)
      S_PG0:   begin mul_a = mag(s0_q);        mul_b = pg_q;   end
      S_PG1:   begin mul_a = mag(s1_q);        mul_b = pg_q;   end
      S_REL:   begin mul_a = want_q - gain_q;  mul_b = rc_q;   end
      S_CLMP0: begin mul_a = ap_c;             mul_b = gain_q; end
      S_OUT0:  begin mul_a = mag(d0_q);        mul_b = g_q;    end
      S_OUT1:  begin mul_a = mag(d1_q);        mul_b = g_q;    end
      default: begin mul_a = '0;               mul_b = '0;     end
    endcase
  end

  // restoring divider step
  logic [24:0]      div_t;
  logic             div_ge;
  logic [23:0]      div_rem_n;
  logic [DIV_N-1:0] div_num_n;
  assign div_t     = {div_rem_q, div_num_q[DIV_N-1]};
  assign div_ge    = (div_t >= {1'b0, div_den_q});
  assign div_rem_n = div_ge ? 24'(div_t - {1'b0, div_den_q}) : div_t[23:0];
  assign div_num_n = {div_num_q[DIV_N-2:0], div_ge};

  logic [46:0] thr_sh;
  assign thr_sh = {thr_q, 23'd0};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ch0_out_o   = out0_q;
  assign ch1_out_o   = out1_q;
  assign gain_now_o  = outg_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 48'(mul_a) * 48'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pg_q        <= 24'd1048576;
      thr_q       <= lpl_pkg::UNITY;
      la_q        <= '0;
      rc_q        <= '0;
      cic_q       <= 2'd2;
      wp_q        <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      sc_q        <= '0;
      gain_q      <= lpl_pkg::UNITY;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lpl_pkg::REG_PRE_GAIN:  pg_q  <= cfg_data_i;
          lpl_pkg::REG_THRESHOLD: thr_q <= cfg_data_i;
          lpl_pkg::REG_LOOKAHEAD: la_q  <= cfg_data_i[8:0];
          lpl_pkg::REG_RELEASE:   rc_q  <= cfg_data_i;
          lpl_pkg::REG_CHANNELS:  cic_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            s0_q    <= ch0_sample_i;
            s1_q    <= ch1_sample_i;
            state_q <= S_PG0;
          end
        end
        S_PG0: state_q <= S_PG1;
        S_PG1: begin
          v0_q    <= sat_val(r20, s0_q[SB-1]);
          a0_q    <= sat_abs(r20, s0_q[SB-1]);
          state_q <= S_PG2;
        end
        S_PG2: begin
          if (fill_q != FW'(LINE_LEN)) begin
            fill_q <= fill_q + 1'b1;
          end
          if (peak_c > thr_q) begin
            div_num_q <= thr_sh;
            div_den_q <= peak_c;
            div_rem_q <= '0;
            div_cnt_q <= 6'(DIV_N);
            state_q   <= S_DIV_T;
          end else begin
            tgt_q   <= lpl_pkg::UNITY;
            state_q <= S_DQT_RD;
          end
        end
        S_DIV_T, S_DIV_C: begin
          div_num_q <= div_num_n;
          div_rem_q <= div_rem_n;
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == 6'd1) begin
            if (state_q == S_DIV_T) begin
              tgt_q   <= div_num_n[23:0];
              state_q <= S_DQT_RD;
            end else begin
              g_q     <= div_num_n[23:0];
              state_q <= S_OUT0;
            end
          end
        end
        S_DQT_RD: state_q <= (tail_q == head_q) ? S_DQ_WR : S_DQT_CHK;
        S_DQT_CHK: begin
          if (dq_rdata[23:0] < tgt_q) begin
            state_q <= S_DQ_WR;
          end else begin
            tail_q  <= dq_dec(tail_q);
            state_q <= S_DQT_RD;
          end
        end
        S_DQ_WR: begin
          tail_q <= dq_inc(tail_q);
          if (dq_inc(tail_q) == head_q) begin
            head_q <= dq_inc(head_q);
          end
          state_q <= S_DQH_RD;
        end
        S_DQH_RD: begin
          if (head_q == tail_q) begin
            want_q  <= tgt_q;
            sc_q    <= sc_q + 1'b1;
            state_q <= S_REL;
          end else begin
            state_q <= S_DQH_CHK;
          end
        end
        S_DQH_CHK: begin
          // expired entry at the head: drop it and look again
          if (AGW'(sc_q - dq_rdata[AGW+23:24]) >= window) begin
            head_q  <= dq_inc(head_q);
            state_q <= S_DQH_RD;
          end else begin
            want_q  <= dq_rdata[23:0];
            sc_q    <= sc_q + 1'b1;
            state_q <= S_REL;
          end
        end
        S_REL: begin
          if (want_q < gain_q) begin
            gain_q  <= want_q;
            state_q <= S_RD;
          end else begin
            state_q <= S_REL2;
          end
        end
        S_REL2: begin
          gain_q  <= want_q - r24[23:0];
          state_q <= S_RD;
        end
        S_RD: state_q <= S_CLMP0;
        S_CLMP0: begin
          ap_q    <= ap_c;
          d0_q    <= ln_valid ? dl_rdata[SB-1:0] : '0;
          d1_q    <= (ln_valid && ch1_act) ? dl_rdata[2*SB-1:SB] : '0;
          state_q <= S_CLMP1;
        end
        S_CLMP1: begin
          if (ap_q != '0 && prod_q > {1'b0, thr_sh}) begin
            div_num_q <= thr_sh;
            div_den_q <= ap_q;
            div_rem_q <= '0;
            div_cnt_q <= 6'(DIV_N);
            state_q   <= S_DIV_C;
          end else begin
            g_q     <= gain_q;
            state_q <= S_OUT0;
          end
        end
        S_OUT0: state_q <= S_OUT1;
        S_OUT1: begin
          o0_q    <= sat_val(r23, d0_q[SB-1]);
          state_q <= S_OUT2;
        end
        S_OUT2: begin
          o1_q    <= sat_val(r23, d1_q[SB-1]);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q) begin
            out0_q      <= o0_q;
            out1_q      <= o1_q;
            outg_q      <= gain_q;
            out_valid_q <= 1'b1;
            wp_q        <= (wp_q == AW'(LINE_LEN - 1)) ? '0 : wp_q + 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lpl_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module lpl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

>>> rtl/core/lpl_checker.sv
// Port-level checker for the limiter core, bound to the core module.
// Depends on lpl_pkg.
`default_nettype none
module lpl_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [lpl_pkg::SAMPLE_BITS-1:0] ch0_out_o,
  input wire logic [lpl_pkg::SAMPLE_BITS-1:0] ch1_out_o,
  input wire logic [lpl_pkg::GAIN_W-1:0]      gain_now_o
);

  // a transaction starts a multi-cycle frame
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(gain_now_o)
      && $stable(ch0_out_o) && $stable(ch1_out_o))
    else $error("stalled result changed");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_now_o <= lpl_pkg::UNITY)
    else $error("gain above unity");

  // results appear only at the end of a frame
  a_result_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without a frame in flight");

endmodule

bind lookahead_peak_limiter_core lpl_checker u_lpl_checker (.*);
`default_nettype wire

>>> bench/tb_lookahead_peak_limiter_core.sv
// Self-checking bench for lookahead_peak_limiter_core: directed frames, then random phases.
// Depends on lpl_pkg and the core RTL; a built-in limiter predictor checks each result.
`timescale 1ns / 1ps
module tb_lookahead_peak_limiter_core;

  localparam int LLEN   = 512;
  localparam int DQ_CAP = LLEN + 2;
  localparam longint SMAX = 8388607;
  localparam longint SMIN = -8388608;

  typedef struct {
    logic signed [lpl_pkg::SAMPLE_BITS-1:0] c0;
    logic signed [lpl_pkg::SAMPLE_BITS-1:0] c1;
    logic [lpl_pkg::GAIN_W-1:0]             g;
  } frame_t;

  typedef struct {
    logic [23:0] a;
    logic [23:0] b;
    bit          typed;
    int          cset;
  } drow_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [lpl_pkg::SAMPLE_BITS-1:0] ch0_sample_i, ch1_sample_i, ch0_out_o, ch1_out_o;
  logic [lpl_pkg::GAIN_W-1:0] gain_now_o;
  logic cfg_we_i;
  logic [lpl_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [lpl_pkg::CFG_DATA_W-1:0] cfg_data_i;

  lookahead_peak_limiter_core uut (.*);

  // predictor state
  logic [23:0] p_pre, p_thr, p_rel;
  logic [8:0]  p_look;
  logic [1:0]  p_chn;
  int signed   dly [2][LLEN];
  int unsigned pk_line [LLEN];
  int unsigned dq_val [DQ_CAP];
  bit [15:0]   dq_age [DQ_CAP];
  int unsigned dq_head, dq_tail, wr_pos;
  bit [15:0]   frame_cnt;
  int unsigned gain_st;

  frame_t expected_q[$];
  int errors, frames_sent, frames_seen, phases;
  int idle_pct, stall_pct, hold_req;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint scale_sat(longint s, longint unsigned g, int sh);
    bit neg;
    longint unsigned mag, r;
    neg = s < 0;
    mag = neg ? longint'(-s) : longint'(s);
    r = (mag * g + (64'd1 << (sh - 1))) >> sh;
    if (neg) return (r > 64'd8388608) ? SMIN : -longint'(r);
    return (r > SMAX) ? SMAX : longint'(r);
  endfunction

  function automatic int unsigned gain_window_min(int unsigned v, int unsigned win);
    int unsigned prev;
    while (dq_tail != dq_head) begin
      prev = (dq_tail + DQ_CAP - 1) % DQ_CAP;
      if (dq_val[prev] < v) break;
      dq_tail = prev;
    end
    dq_val[dq_tail] = v;
    dq_age[dq_tail] = frame_cnt;
    dq_tail = (dq_tail + 1) % DQ_CAP;
    if (dq_tail == dq_head) dq_head = (dq_head + 1) % DQ_CAP;
    while (dq_head != dq_tail && 16'(frame_cnt - dq_age[dq_head]) >= win)
      dq_head = (dq_head + 1) % DQ_CAP;
    frame_cnt = frame_cnt + 16'd1;
    return (dq_head != dq_tail) ? dq_val[dq_head] : v;
  endfunction

  function automatic frame_t limit_frame(logic [23:0] a, logic [23:0] b);
    frame_t res;
    int unsigned nch, look, wp, rp, want;
    longint v, o;
    longint unsigned peak, mg, thr, g, ap, diff, stp;
    logic [23:0] smp [2];
    longint outs [2];
    smp[0] = a;
    smp[1] = b;
    nch = (p_chn == 0) ? 1 : (p_chn > 2) ? 2 : p_chn;
    look = (p_look > 510) ? 510 : p_look;
    wp = wr_pos;
    peak = 0;
    thr = p_thr;
    for (int c = 0; c < 2; c++) begin
      v = 0;
      if (c < nch) begin
        v = scale_sat(longint'($signed(smp[c])), p_pre, 20);
        mg = (v < 0) ? longint'(-v) : longint'(v);
        if (mg > peak) peak = mg;
      end
      dly[c][wp] = int'(v);
    end
    pk_line[wp] = int'(peak);
    want = gain_window_min((peak > thr) ? int'((thr << 23) / peak) : lpl_pkg::UNITY,
                           look + 1);
    if (want < gain_st) gain_st = want;
    else begin
      diff = want - gain_st;
      stp = (diff * p_rel + (64'd1 << 23)) >> 24;
      gain_st = want - int'(stp);
    end
    rp = (wp + LLEN - look) % LLEN;
    ap = pk_line[rp];
    g = gain_st;
    if (ap > 0 && ap * g > (thr << 23)) g = (thr << 23) / ap;
    for (int c = 0; c < 2; c++) begin
      o = 0;
      if (c < nch) o = scale_sat(longint'(dly[c][rp]), g, 23);
      outs[c] = o;
    end
    res.c0 = outs[0][23:0];
    res.c1 = outs[1][23:0];
    res.g  = gain_st[23:0];
    wr_pos = (wp + 1) % LLEN;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s at result %0d: got %0d expected %0d", what, frames_seen, got, want);
  endtask

  // output side: compare each transaction against the oldest expectation
  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (ch0_out_o !== e.c0) report_mismatch("ch0_out", ch0_out_o, e.c0);
        if (ch1_out_o !== e.c1) report_mismatch("ch1_out", ch1_out_o, e.c1);
        if (gain_now_o !== e.g) report_mismatch("gain_now", gain_now_o, e.g);
      end
      frames_seen++;
    end
  end

  // receiver stalls; a hold request forces a long back-pressure stretch
  int hold_left;
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic cfg_write(logic [lpl_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lpl_pkg::REG_PRE_GAIN:  p_pre  = val;
      lpl_pkg::REG_THRESHOLD: p_thr  = val;
      lpl_pkg::REG_LOOKAHEAD: p_look = val[8:0];
      lpl_pkg::REG_RELEASE:   p_rel  = val;
      lpl_pkg::REG_CHANNELS:  p_chn  = val[1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [23:0] pg, logic [23:0] th, logic [23:0] la,
                         logic [23:0] rl, logic [23:0] ch);
    cfg_write(lpl_pkg::REG_PRE_GAIN, pg);
    cfg_write(lpl_pkg::REG_THRESHOLD, th);
    cfg_write(lpl_pkg::REG_LOOKAHEAD, la);
    cfg_write(lpl_pkg::REG_RELEASE, rl);
    cfg_write(lpl_pkg::REG_CHANNELS, ch);
    phases++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_frame(logic [23:0] a, logic [23:0] b, bit typed);
    frame_t f;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    ch0_sample_i <= a;
    ch1_sample_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    f = limit_frame(a, b);
    if (typed) begin
      // default setup passes samples through untouched at unity gain
      f.c0 = a;
      f.c1 = b;
      f.g  = lpl_pkg::UNITY;
    end
    expected_q.push_back(f);
    frames_sent++;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(4095) - 2048);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return $urandom_range(1) ? 24'($urandom_range(8388607, 4000000))
                                        : 24'(-$urandom_range(8388608, 4000000));
    endcase
  endfunction

  function automatic logic [23:0] pick(logic [23:0] lo, logic [23:0] hi, logic [23:0] mid);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      2: return mid;
      default: return 24'($urandom_range(hi, lo));
    endcase
  endfunction

  drow_t dir_tab[$];
  int cur_set;

  initial begin
    errors = 0; frames_sent = 0; frames_seen = 0; phases = 0;
    idle_pct = 0; stall_pct = 0; hold_req = 0; hold_left = 0;
    in_valid_i = 0; ch0_sample_i = 0; ch1_sample_i = 0;
    out_ready_i = 0; cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = 0;
    p_pre = 24'd1048576; p_thr = lpl_pkg::UNITY; p_look = 0; p_rel = 0; p_chn = 2;
    foreach (dly[c, i]) dly[c][i] = 0;
    foreach (pk_line[i]) pk_line[i] = 0;
    foreach (dq_val[i]) begin dq_val[i] = 0; dq_age[i] = 0; end
    dq_head = 0; dq_tail = 0; wr_pos = 0; frame_cnt = 0; gain_st = lpl_pkg::UNITY;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // set 0: reset config; set 1: threshold zero, lookahead past limit, channel count
    // zero; set 2: threshold over full scale, count three, zero pre-gain; set 3: max pre-gain
    dir_tab = '{
      '{24'h000000, 24'h000000, 1, 0}, '{24'h7FFFFF, 24'h800000, 1, 0},
      '{24'h800000, 24'h7FFFFF, 1, 0}, '{24'h000001, 24'hFFFFFF, 1, 0},
      '{24'hFFFFFF, 24'h000001, 1, 0}, '{24'h555555, 24'hAAAAAA, 1, 0},
      '{24'hAAAAAA, 24'h555555, 1, 0}, '{24'h400000, 24'hC00000, 1, 0},
      '{24'h7FFFFF, 24'h7FFFFF, 0, 1}, '{24'h000000, 24'h000000, 0, 1},
      '{24'h000001, 24'h800000, 0, 1}, '{24'h800000, 24'h000000, 0, 1},
      '{24'h123456, 24'hEDCBA9, 0, 1}, '{24'h000000, 24'h000000, 0, 1},
      '{24'h7FFFFF, 24'h800000, 0, 2}, '{24'h000010, 24'hFFFFF0, 0, 2},
      '{24'h800000, 24'h7FFFFF, 0, 2}, '{24'h000000, 24'h000000, 0, 3},
      '{24'h7FFFFF, 24'h000001, 0, 3}, '{24'h000000, 24'h000000, 0, 3},
      '{24'h800000, 24'h123456, 0, 3}, '{24'h000000, 24'h000000, 0, 3},
      '{24'h300000, 24'hD00000, 0, 3}, '{24'h000000, 24'h000000, 0, 3}
    };
    cur_set = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cset != cur_set) begin
        wait_drained();
        cur_set = dir_tab[i].cset;
        case (cur_set)
          1: cfg_all(24'hFFFFFF, 24'd0, 24'd511, 24'd0, 24'd0);
          2: cfg_all(24'd0, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd3);
          default: cfg_all(24'hFFFFFF, 24'd1, 24'd3, 24'h800000, 24'd2);
        endcase
      end
      send_frame(dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed);
    end
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      cfg_all(pick(24'd0, 24'hFFFFFF, 24'd1048576),
              ($urandom_range(4) == 0) ? 24'd0 : pick(24'd1, 24'd8388608, 24'hFFFFFF),
              ($urandom_range(2) == 0) ? pick(24'd0, 24'd511, 24'd510)
                                       : 24'($urandom_range(40)),
              pick(24'd0, 24'hFFFFFF, 24'hFF0000),
              24'($urandom_range(3)));
      for (int k = 0; k < 130; k++) begin
        if (ph == 2 && k == 20) hold_req = 400;
        if (ph == 5 && k == 60) wait_drained();
        send_frame(rand_sample(), rand_sample(), 0);
      end
      wait_drained();
    end

    $display("%0d frames checked over %0d register setups", frames_seen, phases);
    $display("covered idle/stall mixes, long output hold-off, limiter edge settings");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
